// ===== sv/sha_pkg.sv =====
// Package with SHA-256 types, constants and a rotate function.
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } sha_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;   // write in_byte at the current position
    logic pad_byte;    // write pad_value at the current position
    logic pad_len;     // write the bit length into words 14 and 15
    logic clr_pos;     // return to byte position zero
    logic load_work;   // copy hash words into the working words
    logic do_round;    // run one round
    logic add_hash;    // fold working words into hash words
    logic reinit;      // reload initial hash and clear bit count
    logic [7:0] pad_value;
  } sha_cmd_t;

  typedef struct packed {
    logic       block_full; // position is 63 (next byte completes a block)
    logic       pos_is_56;
    logic       last_round;
    logic [5:0] pos;
  } sha_sts_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== sv/sha_datapath.sv =====
// SHA-256 datapath: block buffer, schedule, round logic and hash words.
`default_nettype none
module sha_datapath
  import sha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire sha_cmd_t    cmd_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic [2:0]  rd_idx_i,
  output sha_sts_t         sts_o,
  output logic [31:0]      hash_word_o
);

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [63:0] bits_q;
  logic [5:0]  pos_q;
  logic [5:0]  rnd_q;

  logic [3:0]  t;
  logic [31:0] w15, w2, s0, s1, wnew, wt, t1, t2;
  logic [31:0] bword;
  logic [7:0]  wbyte;
  logic [4:0]  shamt;

  assign t     = rnd_q[3:0];
  assign w15   = w_q[t + 4'd1];
  assign w2    = w_q[t + 4'd14];
  assign s0    = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign s1    = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign wnew  = s1 + w_q[t + 4'd9] + s0 + w_q[t];
  assign wt    = (rnd_q >= 6'd16) ? wnew : w_q[t];
  assign t1    = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
               + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + wt;
  assign t2    = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
               + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign wbyte = cmd_i.take_byte ? in_byte_i : cmd_i.pad_value;
  assign shamt = {~pos_q[1:0], 3'b000};
  // A byte in the first slot of a word clears the rest of that word.
  assign bword = ((pos_q[1:0] == 2'd0) ? 32'd0 : w_q[pos_q[5:2]])
               | ({24'd0, wbyte} << shamt);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte || cmd_i.pad_byte) begin
      w_q[pos_q[5:2]] <= bword;
    end else if (cmd_i.pad_len) begin
      w_q[14] <= bits_q[63:32];
      w_q[15] <= bits_q[31:0];
    end else if (cmd_i.do_round) begin
      w_q[t] <= wt;
    end
    if (cmd_i.load_work) begin
      v_q <= h_q;
    end else if (cmd_i.do_round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= H_INIT;
      bits_q <= '0;
      pos_q  <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.reinit) begin
        h_q    <= H_INIT;
        bits_q <= '0;
      end else begin
        if (cmd_i.add_hash) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        if (cmd_i.take_byte) bits_q <= bits_q + 64'd8;
      end
      if (cmd_i.clr_pos) pos_q <= '0;
      else if (cmd_i.take_byte || cmd_i.pad_byte) pos_q <= pos_q + 6'd1;
      if (cmd_i.load_work) rnd_q <= '0;
      else if (cmd_i.do_round) rnd_q <= rnd_q + 6'd1;
    end
  end

  assign sts_o.block_full = (pos_q == 6'd63);
  assign sts_o.pos_is_56  = (pos_q == 6'd56);
  assign sts_o.last_round = (rnd_q == 6'd63);
  assign sts_o.pos        = pos_q;
  assign hash_word_o      = h_q[rd_idx_i];

endmodule
`default_nettype wire

// ===== sv/sha_ctrl.sv =====
// SHA-256 controller: byte intake, padding, round sequencing and digest output.
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sha_in_t  in_data_i,
  input  wire sha_sts_t sts_i,
  input  wire logic     out_fire_i,
  output logic          out_load_o,
  output logic [2:0]    rd_idx_o,
  output logic          last_idx_o,
  output logic          busy_o,
  output sha_cmd_t      cmd_o
);

  sha_state_e state_q, state_d;
  logic       final_q, final_d;   // current compression is the padded last one
  logic       first_q, first_d;   // 0x80 not yet placed
  logic       pend_q, pend_d;     // end mark waits behind a block-filling byte
  logic [2:0] idx_q, idx_d;
  logic       ovalid_q, ovalid_d; // mirrors the output register's fullness
  logic       in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    final_d  = final_q;
    first_d  = first_q;
    pend_d   = pend_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q && !out_fire_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          first_d = 1'b1;
          final_d = 1'b0;
          // A byte that fills a block with the end mark set pads after the
          // compression of that block.
          pend_d  = in_data_i.has_byte && sts_i.block_full && in_data_i.end_of_message;
          if (in_data_i.has_byte && sts_i.block_full) begin
            state_d = ST_LOAD;
          end else if (in_data_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (sts_i.pos_is_56 && !first_q) begin
          state_d = ST_LOAD;
          final_d = 1'b1;
        end else if (sts_i.block_full) begin
          state_d = ST_LOAD;
          final_d = 1'b0;
          first_d = 1'b0;
        end else begin
          first_d = 1'b0;
        end
      end
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: if (sts_i.last_round) state_d = ST_ADD;
      ST_ADD: begin
        if (final_q) begin
          state_d = ST_EMIT;
          idx_d   = '0;
        end else if (pend_q || !first_q) begin
          state_d = ST_PAD;
          pend_d  = 1'b0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!ovalid_q || out_fire_i) begin
          ovalid_d = 1'b1;
          idx_d    = idx_q + 3'd1;
          if (idx_q == 3'd7) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.pad_value = first_q ? PAD_MARK : 8'h00;
    in_ready_o      = 1'b0;
    out_load_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = in_fire && in_data_i.has_byte;
      end
      ST_PAD: begin
        if (sts_i.pos_is_56 && !first_q) cmd_o.pad_len = 1'b1;
        else cmd_o.pad_byte = 1'b1;
      end
      ST_LOAD:  cmd_o.load_work = 1'b1;
      ST_ROUND: cmd_o.do_round  = 1'b1;
      ST_ADD: begin
        cmd_o.add_hash = 1'b1;
        cmd_o.clr_pos  = final_q;
      end
      ST_EMIT: begin
        out_load_o   = !ovalid_q || out_fire_i;
        cmd_o.reinit = out_load_o && (idx_q == 3'd7);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      final_q  <= 1'b0;
      first_q  <= 1'b1;
      pend_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      final_q  <= final_d;
      first_q  <= first_d;
      pend_q   <= pend_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign rd_idx_o   = idx_q;
  assign last_idx_o = (idx_q == 3'd7);
  assign busy_o     = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== sv/sha256_hasher.sv =====
// SHA-256 hasher top level: controller, datapath and output register.
//
// Usage: message bytes enter as beats on the in channel (valid/ready), one
// byte per beat in message order. A beat with end_of_message set closes the
// message; it may carry a byte or none (has_byte low), which allows the
// empty message. A beat with neither flag does nothing.
// Each byte is stored as it is taken. Every 64th byte starts a compression
// of a load step, the rounds (one round per cycle on a single round unit)
// and an add step, during which in_ready_o is low. On the end beat the
// block writes its own padding one byte per cycle up to byte 56 (with a
// second block, up to 64 and then 56 more), then the length, and
// compresses once or twice more.
// The eight digest words then leave as beats on the out channel, word 0
// first, each with its index and last_word on word 7. They pass through an
// output register, so a stalled receiver simply holds the current word and
// the block waits; after word 7 is loaded the initial hash values are back
// and a new message may begin.
// Reset (rst_ni low, asynchronous) returns to idle with the initial hash
// values, zero length and an empty output register.
`default_nettype none
module sha256_hasher
  import sha_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sha_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sha_out_t      out_data_o
);

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic        out_load, last_idx, busy, out_fire;
  logic [2:0]  rd_idx;
  logic [31:0] hash_word;
  logic        out_valid_q;
  sha_out_t    out_data_q;

  assign out_fire = out_valid_q && out_ready_i;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .sts_i(sts), .out_fire_i(out_fire), .out_load_o(out_load),
    .rd_idx_o(rd_idx), .last_idx_o(last_idx), .busy_o(busy), .cmd_o(cmd)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_byte_i(in_data_i.data_byte),
    .rd_idx_i(rd_idx), .sts_o(sts), .hash_word_o(hash_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.digest_word <= hash_word;
      out_data_q.word_index  <= rd_idx;
      out_data_q.last_word   <= last_idx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Input is only taken while the controller is idle.
  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o) else $error("input accepted while busy");

  // A loaded word that is not taken stays in the output register.
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_data_q))
    else $error("output word dropped");

  // The controller never overwrites an output word that was not taken.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i)) else $error("output overrun");

endmodule
`default_nettype wire
